[src/gpr_pkg.sv]
package gpr_pkg;

	localparam int SINE_DEPTH = 256;
	localparam int IDX_W      = $clog2(SINE_DEPTH + 1);
	localparam int PROD_W     = 14 + IDX_W;
	localparam longint PI_HALF_Q30 = 64'sd1686629713;

	localparam int MW  = 19;
	localparam int XW  = 32;
	localparam int TW  = 54;
	localparam int PW  = 40;
	localparam int ZW  = PW + 17;
	localparam int OUT_W = 24;

	// Rounded-up reciprocals in Q64 of the Taylor divisors (2k)(2k+1), k = 1..9.
	localparam logic [127:0] TAYLOR_RCP [1:9] = '{
		((128'd1 << 64) + 128'd5) / 128'd6,
		((128'd1 << 64) + 128'd19) / 128'd20,
		((128'd1 << 64) + 128'd41) / 128'd42,
		((128'd1 << 64) + 128'd71) / 128'd72,
		((128'd1 << 64) + 128'd109) / 128'd110,
		((128'd1 << 64) + 128'd155) / 128'd156,
		((128'd1 << 64) + 128'd209) / 128'd210,
		((128'd1 << 64) + 128'd271) / 128'd272,
		((128'd1 << 64) + 128'd341) / 128'd342
	};

	typedef enum logic [2:0] {
		REG_ANGLE_X   = 3'd0,
		REG_ANGLE_Y   = 3'd1,
		REG_ANGLE_Z   = 3'd2,
		REG_HSCALE    = 3'd3,
		REG_ZOOM      = 3'd4,
		REG_OFFSET_X  = 3'd5,
		REG_OFFSET_Y  = 3'd6,
		REG_UNUSED    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic        [15:0] angle_x;
		logic        [15:0] angle_y;
		logic        [15:0] angle_z;
		logic signed [15:0] height_scale;
		logic        [15:0] zoom;
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_y;
	} cfg_t;

	typedef struct packed {
		logic        [9:0]  col;
		logic        [9:0]  row;
		logic signed [31:0] pz;
	} point_t;

	typedef logic signed [MW-1:0] mat_t [3][3];
	typedef logic [15:0] sine_tab_t [SINE_DEPTH+1];

	function automatic sine_tab_t build_sine();
		sine_tab_t          tab;
		longint unsigned    x;
		longint unsigned    term;
		longint             sum;
		longint             e;
		for (int i = 0; i <= SINE_DEPTH; i++) begin
			x    = longint'((PI_HALF_Q30 * longint'(i)) / SINE_DEPTH);
			term = x;
			sum  = longint'(x);
			for (int k = 1; k <= 9; k++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = 64'((128'(term) * TAYLOR_RCP[k]) >> 64);
				if (k % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			e = (sum + 16384) >>> 15;
			if (e > 32767) begin
				e = 32767;
			end
			tab[i] = 16'(e);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine();

	function automatic logic signed [15:0] sine_q15(input logic [15:0] a);
		logic [PROD_W-1:0] prod;
		logic [IDX_W-1:0]  idx;
		logic signed [15:0] v;
		prod = PROD_W'(a[13:0]) * PROD_W'(SINE_DEPTH);
		idx  = IDX_W'(prod >> 14);
		if (a[14]) begin
			idx = IDX_W'(SINE_DEPTH) - idx;
		end
		v = $signed(SINE_TAB[idx]);
		return a[15] ? -v : v;
	endfunction

	function automatic logic signed [15:0] cosine_q15(input logic [15:0] a);
		return sine_q15(a + 16'd16384);
	endfunction

endpackage

[src/gpr_matrix.sv]
module gpr_matrix import gpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [9:0]  col,
	input  logic [9:0]  row,
	input  logic signed [15:0] height,
	input  cfg_t        cfg,
	output logic        m_valid,
	output mat_t        m,
	output point_t      pt
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [15:0] sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;
	logic signed [15:0] sz_s2, cz_s2;
	logic signed [XW-1:0] xy_s2 [3][3];
	logic signed [47:0] p0_s3 [3];
	logic signed [47:0] p1_s3 [3];
	logic signed [47:0] q0_s3 [3];
	logic signed [47:0] q1_s3 [3];
	logic signed [XW-1:0] x2_s3 [3];
	mat_t m_s4;
	point_t pt_s1, pt_s2, pt_s3, pt_s4;
	logic signed [31:0] hprod;

	assign hprod = height * cfg.height_scale;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		sx_s1 <= sine_q15(cfg.angle_x);
		cx_s1 <= cosine_q15(cfg.angle_x);
		sy_s1 <= sine_q15(cfg.angle_y);
		cy_s1 <= cosine_q15(cfg.angle_y);
		sz_s1 <= sine_q15(cfg.angle_z);
		cz_s1 <= cosine_q15(cfg.angle_z);
		pt_s1.col <= col;
		pt_s1.row <= row;
		pt_s1.pz  <= -hprod;

		xy_s2[0][0] <= XW'(cy_s1) <<< 15;
		xy_s2[0][1] <= '0;
		xy_s2[0][2] <= -(XW'(sy_s1) <<< 15);
		xy_s2[1][0] <= XW'(sx_s1 * sy_s1);
		xy_s2[1][1] <= XW'(cx_s1) <<< 15;
		xy_s2[1][2] <= XW'(sx_s1 * cy_s1);
		xy_s2[2][0] <= XW'(cx_s1 * sy_s1);
		xy_s2[2][1] <= -(XW'(sx_s1) <<< 15);
		xy_s2[2][2] <= XW'(cx_s1 * cy_s1);
		sz_s2 <= sz_s1;
		cz_s2 <= cz_s1;
		pt_s2 <= pt_s1;

		for (int r = 0; r < 3; r++) begin
			p0_s3[r] <= 48'(xy_s2[r][0] * cz_s2);
			p1_s3[r] <= 48'(xy_s2[r][1] * sz_s2);
			q0_s3[r] <= 48'(xy_s2[r][0] * sz_s2);
			q1_s3[r] <= 48'(xy_s2[r][1] * cz_s2);
			x2_s3[r] <= xy_s2[r][2];
		end
		pt_s3 <= pt_s2;

		for (int r = 0; r < 3; r++) begin
			m_s4[r][0] <= MW'((50'(p0_s3[r]) - 50'(p1_s3[r]) + 50'sd268435456) >>> 29);
			m_s4[r][1] <= MW'((50'(q0_s3[r]) + 50'(q1_s3[r]) + 50'sd268435456) >>> 29);
			m_s4[r][2] <= MW'((34'(x2_s3[r]) + 34'sd8192) >>> 14);
		end
		pt_s4 <= pt_s3;
	end

	assign m_valid = valid_s4;
	assign m       = m_s4;
	assign pt      = pt_s4;

endmodule

[src/gpr_project.sv]
module gpr_project import gpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        m_valid,
	input  mat_t        m,
	input  point_t      pt,
	input  cfg_t        cfg,
	output logic        done,
	output logic signed [OUT_W-1:0] screen_x,
	output logic signed [OUT_W-1:0] screen_y
);

	localparam logic signed [ZW+1:0] OUT_MAX = (ZW+2)'(8388607);
	localparam logic signed [ZW+1:0] OUT_MIN = -(ZW+2)'(8388608);

	logic valid_s5, valid_s6, valid_s7, valid_s8;
	logic signed [TW-1:0] pr_s5 [3][3];
	logic signed [PW-1:0] px_s6, py_s6;
	logic signed [ZW-1:0] zx_s7, zy_s7;
	logic signed [OUT_W-1:0] sx_s8, sy_s8;
	logic signed [18:0] ux, uy;
	logic signed [TW-1:0] t0, t1, t2;
	logic signed [TW+1:0] dx, dy;
	logic signed [ZW+1:0] rx, ry;

	assign ux = $signed({1'b0, pt.col, 8'b0});
	assign uy = $signed({1'b0, pt.row, 8'b0});

	assign t0 = pr_s5[0][0] + pr_s5[0][1] + pr_s5[0][2];
	assign t1 = pr_s5[1][0] + pr_s5[1][1] + pr_s5[1][2];
	assign t2 = pr_s5[2][0] + pr_s5[2][1] + pr_s5[2][2];
	assign dx = (TW+2)'(t0) - (TW+2)'(t1) + (TW+2)'(32768);
	assign dy = ((TW+2)'(t2) <<< 1) + (TW+2)'(t0) + (TW+2)'(t1) + (TW+2)'(65536);

	assign rx = (((ZW+2)'(zx_s7) + (ZW+2)'(32768)) >>> 16) + (ZW+2)'(cfg.offset_x);
	assign ry = (((ZW+2)'(zy_s7) + (ZW+2)'(32768)) >>> 16) + (ZW+2)'(cfg.offset_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s5 <= m_valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			pr_s5[r][0] <= TW'(ux * m[r][0]);
			pr_s5[r][1] <= TW'(uy * m[r][1]);
			pr_s5[r][2] <= TW'(pt.pz * m[r][2]);
		end

		px_s6 <= PW'(dx >>> 16);
		py_s6 <= PW'(dy >>> 17);

		zx_s7 <= ZW'(px_s6 * $signed({1'b0, cfg.zoom}));
		zy_s7 <= ZW'(py_s6 * $signed({1'b0, cfg.zoom}));

		if (rx > OUT_MAX) begin
			sx_s8 <= OUT_W'(OUT_MAX);
		end else if (rx < OUT_MIN) begin
			sx_s8 <= OUT_W'(OUT_MIN);
		end else begin
			sx_s8 <= OUT_W'(rx);
		end
		if (ry > OUT_MAX) begin
			sy_s8 <= OUT_W'(OUT_MAX);
		end else if (ry < OUT_MIN) begin
			sy_s8 <= OUT_W'(OUT_MIN);
		end else begin
			sy_s8 <= OUT_W'(ry);
		end
	end

	assign done     = valid_s8;
	assign screen_x = sx_s8;
	assign screen_y = sy_s8;

endmodule

[src/grid_point_rotate_project.sv]
// A taken start flows through gpr_matrix, then gpr_project, and exits with done.
// Throughput: one transaction per cycle; busy stays low, as the eight-stage
// pipeline has no stall path and the receiver cannot hold results off.
// Reset (arst_n low) clears all valid bits and loads the register reset values.
module grid_point_rotate_project import gpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [9:0]  grid_col,
	input  logic [9:0]  grid_row,
	input  logic signed [15:0] height,
	output logic        done,
	output logic signed [23:0] screen_x,
	output logic signed [23:0] screen_y,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t   cfg_q;
	logic   m_valid;
	mat_t   m;
	point_t pt;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_x      <= '0;
			cfg_q.angle_y      <= '0;
			cfg_q.angle_z      <= '0;
			cfg_q.height_scale <= 16'sd256;
			cfg_q.zoom         <= 16'd256;
			cfg_q.offset_x     <= '0;
			cfg_q.offset_y     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_ANGLE_X:  cfg_q.angle_x      <= cfg_data;
				REG_ANGLE_Y:  cfg_q.angle_y      <= cfg_data;
				REG_ANGLE_Z:  cfg_q.angle_z      <= cfg_data;
				REG_HSCALE:   cfg_q.height_scale <= $signed(cfg_data);
				REG_ZOOM:     cfg_q.zoom         <= cfg_data;
				REG_OFFSET_X: cfg_q.offset_x     <= $signed(cfg_data);
				REG_OFFSET_Y: cfg_q.offset_y     <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	gpr_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.col      (grid_col),
		.row      (grid_row),
		.height   (height),
		.cfg      (cfg_q),
		.m_valid  (m_valid),
		.m        (m),
		.pt       (pt)
	);

	gpr_project u_project (
		.clk      (clk),
		.arst_n   (arst_n),
		.m_valid  (m_valid),
		.m        (m),
		.pt       (pt),
		.cfg      (cfg_q),
		.done     (done),
		.screen_x (screen_x),
		.screen_y (screen_y)
	);

`ifndef SYNTH
	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##8 done)
		else $error("transaction did not complete after eight cycles");

	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid |-> ##4 done)
		else $error("matrix stage result lost in projection pipeline");
`endif

endmodule
